@@ rtl/assert_macros.svh @@
// Assertion helpers for the hasher core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising clock edge outside reset.
`define SHA_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: assertion failed");

// Check that a condition implies a consequence in the same cycle.
`define SHA_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

`else

`define SHA_ASSERT(name, clk, rst_n, prop)
`define SHA_ASSERT_IMPL(name, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/sha_pkg.sv @@
package sha_pkg;

  typedef logic [31:0] word_t;

  // Request codes on the input channel
  localparam logic REQ_APPEND = 1'b0;
  localparam logic REQ_FINISH = 1'b1;

  // Block geometry and padding
  localparam int unsigned ROUNDS       = 64;
  localparam int unsigned DIGEST_WORDS = 8;
  localparam int unsigned LEN_OFFSET   = 56;
  localparam logic [7:0]  PAD_MARK     = 8'h80;
  localparam logic [5:0]  FILL_LAST    = 6'd63;
  localparam logic [5:0]  FILL_PAD_END = 6'(LEN_OFFSET - 1);
  localparam logic [5:0]  ROUND_LAST   = 6'(ROUNDS - 1);
  localparam logic [2:0]  LAST_IDX     = 3'(DIGEST_WORDS - 1);

  // Queue sizes (powers of two)
  localparam int unsigned CMD_DEPTH = 4;
  localparam int unsigned CMD_PTR_W = $clog2(CMD_DEPTH);
  localparam int unsigned CMD_CNT_W = $clog2(CMD_DEPTH + 1);
  localparam int unsigned OUT_DEPTH = 8;
  localparam int unsigned OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int unsigned OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_BYTE,
    CMD_FINISH,
    CMD_ERROR
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [7:0]  data;
    logic [63:0] bit_len;
  } cmd_t;

  typedef struct packed {
    word_t      digest_word;
    logic [2:0] word_index;
    logic       last_word;
    logic       overflow;
  } result_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_ZERO,
    BK_LEN,
    BK_ROUND,
    BK_FOLD,
    BK_EMIT
  } back_state_e;

  localparam word_t INIT_CHAIN [DIGEST_WORDS] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  localparam word_t ROUND_K [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

@@ rtl/sha256_byte_stream_hasher_core.sv @@
// SHA-256 hasher over a byte stream.
// Input channel (push/full): each transfer carries req_type_i and data_byte_i.
//   req_type_i = 0 appends data_byte_i to the message, 1 closes the message.
// Result channel (empty/pop): the head result sits on digest_word_o,
//   word_index_o, last_word_o and overflow_o while empty is low.
// A closed message yields eight words, index 0 first, last_word_o on index 7.
//   If the message reached 2^64 bits it yields one word of zero with
//   overflow_o and last_word_o set.
// Throughput: the compression unit takes one byte per cycle while it is idle,
//   and every 64th byte detours through the round and fold states.
// On a close, padding feeds one byte per cycle up to the block end
//   (9 to 72 bytes, one or two blocks), each padded block runs rounds and fold,
//   then the digest leaves one word per cycle while the result queue has room.
// A 4-entry command queue decouples the input from the compression unit and
//   an 8-entry result queue absorbs the digest; when the receiver stalls the
//   result queue fills, the compression unit waits, and full rises.
// Reset clears both queues, the length and loads the standard initial values.
`include "assert_macros.svh"

module sha256_byte_stream_hasher_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic        req_type_i,
  input  logic [7:0]  data_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o,
  output logic        overflow_o
);

  sha_pkg::cmd_t    cmd_in, cmd_out;
  sha_pkg::result_t res_in, res_out;
  logic             cmd_push, cmd_full, cmd_valid, cmd_pop;
  logic             res_push, res_full;
  logic             last_shape_ok, err_word_ok;

  assign full = cmd_full;

  sha_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .req_type_i   (req_type_i),
    .data_byte_i  (data_byte_i),
    .queue_full_i (cmd_full),
    .cmd_push_o   (cmd_push),
    .cmd_o        (cmd_in)
  );

  sha_cmd_queue u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .valid_o (cmd_valid),
    .data_o  (cmd_out)
  );

  sha_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  sha_out_queue u_out_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (res_out)
  );

  assign digest_word_o = res_out.digest_word;
  assign word_index_o  = res_out.word_index;
  assign last_word_o   = res_out.last_word;
  assign overflow_o    = res_out.overflow;

  // Legal shapes of the final word and of the error word
  assign last_shape_ok = (word_index_o == sha_pkg::LAST_IDX && !overflow_o) ||
                         (word_index_o == 3'd0 && overflow_o);
  assign err_word_ok   = (digest_word_o == 32'd0) && last_word_o;

  `SHA_ASSERT_IMPL(a_cmd_no_overrun, clk_i, rst_ni, cmd_push, !cmd_full)
  `SHA_ASSERT_IMPL(a_res_no_overrun, clk_i, rst_ni, res_push, !res_full)
  `SHA_ASSERT_IMPL(a_last_word_shape, clk_i, rst_ni, !empty && last_word_o, last_shape_ok)
  `SHA_ASSERT_IMPL(a_error_word_zero, clk_i, rst_ni, !empty && overflow_o, err_word_ok)

endmodule

@@ rtl/sha_front.sv @@
module sha_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic          req_type_i,
  input  logic [7:0]    data_byte_i,
  input  logic          queue_full_i,
  output logic          cmd_push_o,
  output sha_pkg::cmd_t cmd_o
);

  logic [60:0] byte_cnt_q, byte_cnt_d;
  logic        ovf_q, ovf_d;
  logic [60:0] cnt_inc;
  logic        cnt_carry;
  logic        accept;

  assign accept = push_i & ~queue_full_i;
  assign {cnt_carry, cnt_inc} = {1'b0, byte_cnt_q} + 62'd1;

  // Classify each transfer and track the message length
  always_comb begin
    byte_cnt_d     = byte_cnt_q;
    ovf_d          = ovf_q;
    cmd_push_o     = 1'b0;
    cmd_o.kind     = sha_pkg::CMD_BYTE;
    cmd_o.data     = data_byte_i;
    cmd_o.bit_len  = {byte_cnt_q, 3'b000};
    if (accept) begin
      if (req_type_i == sha_pkg::REQ_FINISH) begin
        cmd_push_o = 1'b1;
        cmd_o.kind = ovf_q ? sha_pkg::CMD_ERROR : sha_pkg::CMD_FINISH;
        byte_cnt_d = '0;
        ovf_d      = 1'b0;
      end else if (!ovf_q) begin
        byte_cnt_d = cnt_inc;
        // drop the byte that wraps the length; the message is already lost
        if (cnt_carry) begin
          ovf_d = 1'b1;
        end else begin
          cmd_push_o = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_cnt_q <= '0;
      ovf_q      <= 1'b0;
    end else begin
      byte_cnt_q <= byte_cnt_d;
      ovf_q      <= ovf_d;
    end
  end

endmodule

@@ rtl/sha_cmd_queue.sv @@
module sha_cmd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  sha_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output sha_pkg::cmd_t data_o
);

  sha_pkg::cmd_t                     mem_q [sha_pkg::CMD_DEPTH];
  logic [sha_pkg::CMD_PTR_W-1:0]     wr_q, rd_q;
  logic [sha_pkg::CMD_CNT_W-1:0]     cnt_q;
  logic                              wr_en, rd_en;

  assign full_o  = (cnt_q == sha_pkg::CMD_CNT_W'(sha_pkg::CMD_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign wr_en   = push_i & ~full_o;
  assign rd_en   = pop_i & valid_o;
  assign data_o  = mem_q[rd_q];

  // Store entries
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_q] <= data_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr_en) begin
        wr_q <= wr_q + 1'b1;
      end
      if (rd_en) begin
        rd_q <= rd_q + 1'b1;
      end
      case ({wr_en, rd_en})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

@@ rtl/sha_out_queue.sv @@
module sha_out_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  sha_pkg::result_t data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output sha_pkg::result_t data_o
);

  sha_pkg::result_t              mem_q [sha_pkg::OUT_DEPTH];
  logic [sha_pkg::OUT_PTR_W-1:0] wr_q, rd_q;
  logic [sha_pkg::OUT_CNT_W-1:0] cnt_q;
  logic                          wr_en, rd_en;

  assign full_o  = (cnt_q == sha_pkg::OUT_CNT_W'(sha_pkg::OUT_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign wr_en   = push_i & ~full_o;
  assign rd_en   = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_q];

  // Store results
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_q] <= data_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr_en) begin
        wr_q <= wr_q + 1'b1;
      end
      if (rd_en) begin
        rd_q <= rd_q + 1'b1;
      end
      case ({wr_en, rd_en})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

@@ rtl/sha_back.sv @@
module sha_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cmd_valid_i,
  input  sha_pkg::cmd_t    cmd_i,
  output logic             cmd_pop_o,
  input  logic             res_full_i,
  output logic             res_push_o,
  output sha_pkg::result_t res_o
);

  sha_pkg::back_state_e state_q, state_d, resume_q, resume_d, after_ins, pad_next;
  logic [5:0]           fill_q, fill_d;
  logic [23:0]          acc_q, acc_d;
  sha_pkg::word_t       w_q [16];
  sha_pkg::word_t       w_d [16];
  sha_pkg::word_t       v_q [8];
  sha_pkg::word_t       v_d [8];
  sha_pkg::word_t       chain_q [sha_pkg::DIGEST_WORDS];
  sha_pkg::word_t       chain_d [sha_pkg::DIGEST_WORDS];
  logic [5:0]           round_q, round_d;
  logic [63:0]          len_q, len_d;
  logic [2:0]           idx_q, idx_d;

  logic                 ins_en;
  logic [7:0]           ins_byte;
  logic                 len_load, len_shift, round_en, fold_en, emit_adv, chain_clear;
  sha_pkg::word_t       t1, t2, w_new;

  function automatic sha_pkg::word_t big_s0(input sha_pkg::word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic sha_pkg::word_t big_s1(input sha_pkg::word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic sha_pkg::word_t small_s0(input sha_pkg::word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic sha_pkg::word_t small_s1(input sha_pkg::word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

  assign pad_next = (fill_q == sha_pkg::FILL_PAD_END) ? sha_pkg::BK_LEN : sha_pkg::BK_ZERO;

  // Next state; a byte that completes the block detours through the rounds
  always_comb begin
    state_d   = state_q;
    resume_d  = resume_q;
    after_ins = state_q;
    unique case (state_q)
      sha_pkg::BK_IDLE: begin
        if (cmd_valid_i && cmd_i.kind == sha_pkg::CMD_FINISH) begin
          after_ins = pad_next;
        end else begin
          after_ins = sha_pkg::BK_IDLE;
        end
      end
      sha_pkg::BK_ZERO: begin
        after_ins = pad_next;
      end
      sha_pkg::BK_LEN: begin
        after_ins = (idx_q == sha_pkg::LAST_IDX) ? sha_pkg::BK_EMIT : sha_pkg::BK_LEN;
      end
      sha_pkg::BK_ROUND: begin
        if (round_q == sha_pkg::ROUND_LAST) begin
          state_d = sha_pkg::BK_FOLD;
        end
      end
      sha_pkg::BK_FOLD: begin
        state_d = resume_q;
      end
      sha_pkg::BK_EMIT: begin
        if (!res_full_i && idx_q == sha_pkg::LAST_IDX) begin
          state_d = sha_pkg::BK_IDLE;
        end
      end
      default: begin
        state_d = sha_pkg::BK_IDLE;
      end
    endcase
    if (ins_en) begin
      if (fill_q == sha_pkg::FILL_LAST) begin
        state_d  = sha_pkg::BK_ROUND;
        resume_d = after_ins;
      end else begin
        state_d = after_ins;
      end
    end
  end

  // Control outputs per state
  always_comb begin
    cmd_pop_o   = 1'b0;
    res_push_o  = 1'b0;
    res_o       = '0;
    ins_en      = 1'b0;
    ins_byte    = '0;
    len_load    = 1'b0;
    len_shift   = 1'b0;
    round_en    = 1'b0;
    fold_en     = 1'b0;
    emit_adv    = 1'b0;
    chain_clear = 1'b0;
    unique case (state_q)
      sha_pkg::BK_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.kind)
            sha_pkg::CMD_BYTE: begin
              cmd_pop_o = 1'b1;
              ins_en    = 1'b1;
              ins_byte  = cmd_i.data;
            end
            sha_pkg::CMD_FINISH: begin
              cmd_pop_o = 1'b1;
              ins_en    = 1'b1;
              ins_byte  = sha_pkg::PAD_MARK;
              len_load  = 1'b1;
            end
            sha_pkg::CMD_ERROR: begin
              if (!res_full_i) begin
                cmd_pop_o       = 1'b1;
                res_push_o      = 1'b1;
                res_o.last_word = 1'b1;
                res_o.overflow  = 1'b1;
                chain_clear     = 1'b1;
              end
            end
            default: begin
              cmd_pop_o = 1'b1;
            end
          endcase
        end
      end
      sha_pkg::BK_ZERO: begin
        ins_en = 1'b1;
      end
      sha_pkg::BK_LEN: begin
        ins_en    = 1'b1;
        ins_byte  = len_q[63:56];
        len_shift = 1'b1;
      end
      sha_pkg::BK_ROUND: begin
        round_en = 1'b1;
      end
      sha_pkg::BK_FOLD: begin
        fold_en = 1'b1;
      end
      sha_pkg::BK_EMIT: begin
        if (!res_full_i) begin
          res_push_o        = 1'b1;
          emit_adv          = 1'b1;
          res_o.digest_word = chain_q[idx_q];
          res_o.word_index  = idx_q;
          res_o.last_word   = (idx_q == sha_pkg::LAST_IDX);
          chain_clear       = (idx_q == sha_pkg::LAST_IDX);
        end
      end
      default: begin
      end
    endcase
  end

  // Round function and schedule extension
  assign t1 = v_q[7] + big_s1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
            + sha_pkg::ROUND_K[round_q] + w_q[0];
  assign t2 = big_s0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
  assign w_new = small_s1(w_q[14]) + w_q[9] + small_s0(w_q[1]) + w_q[0];

  // Datapath updates
  always_comb begin
    fill_d  = fill_q;
    acc_d   = acc_q;
    w_d     = w_q;
    v_d     = v_q;
    chain_d = chain_q;
    round_d = round_q;
    len_d   = len_q;
    idx_d   = idx_q;

    // pack bytes big-endian and shift whole words into the window
    if (ins_en) begin
      acc_d  = {acc_q[15:0], ins_byte};
      fill_d = fill_q + 1'b1;
      if (fill_q[1:0] == 2'b11) begin
        for (int i = 0; i < 15; i++) begin
          w_d[i] = w_q[i+1];
        end
        w_d[15] = {acc_q, ins_byte};
      end
      if (fill_q == sha_pkg::FILL_LAST) begin
        v_d     = chain_q;
        round_d = '0;
      end
    end

    if (len_load) begin
      len_d = cmd_i.bit_len;
      idx_d = '0;
    end

    // length bytes leave the top; index wraps to zero for the emit phase
    if (len_shift) begin
      len_d = {len_q[55:0], 8'h00};
      idx_d = idx_q + 1'b1;
    end

    if (round_en) begin
      round_d = round_q + 1'b1;
      v_d[0]  = t1 + t2;
      v_d[1]  = v_q[0];
      v_d[2]  = v_q[1];
      v_d[3]  = v_q[2];
      v_d[4]  = v_q[3] + t1;
      v_d[5]  = v_q[4];
      v_d[6]  = v_q[5];
      v_d[7]  = v_q[6];
      for (int i = 0; i < 15; i++) begin
        w_d[i] = w_q[i+1];
      end
      w_d[15] = w_new;
    end

    if (fold_en) begin
      for (int i = 0; i < sha_pkg::DIGEST_WORDS; i++) begin
        chain_d[i] = chain_q[i] + v_q[i];
      end
    end

    if (emit_adv) begin
      idx_d = idx_q + 1'b1;
    end

    if (chain_clear) begin
      chain_d = sha_pkg::INIT_CHAIN;
      fill_d  = '0;
    end
  end

  // Control and chaining registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= sha_pkg::BK_IDLE;
      resume_q <= sha_pkg::BK_IDLE;
      fill_q   <= '0;
      round_q  <= '0;
      idx_q    <= '0;
      chain_q  <= sha_pkg::INIT_CHAIN;
    end else begin
      state_q  <= state_d;
      resume_q <= resume_d;
      fill_q   <= fill_d;
      round_q  <= round_d;
      idx_q    <= idx_d;
      chain_q  <= chain_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    w_q   <= w_d;
    v_q   <= v_d;
    len_q <= len_d;
  end

endmodule

@@ sim/sha256_digest_words_pkg.sv @@
`timescale 1ns / 1ps

package sha256_digest_words_pkg;

  localparam logic [31:0] HASH_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_CONST [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Running SHA-256 of the accepted byte stream and the digest words it owes
  class sha256_digest_words;
    logic [7:0]         msg_block [64];
    int unsigned        fill;
    logic [63:0]        bit_len;
    logic [31:0]        chain [8];
    bit                 len_wrapped;
    sha_pkg::result_t   owed_words [$];
    int unsigned        mismatch_count;
    int unsigned        words_seen;

    function new();
      mismatch_count = 0;
      words_seen     = 0;
      restart();
    endfunction

    // Return to the state of a fresh message
    function void restart();
      foreach (msg_block[i]) msg_block[i] = '0;
      chain       = HASH_IV;
      fill        = 0;
      bit_len     = '0;
      len_wrapped = 1'b0;
    endfunction

    function logic [31:0] rotr(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
    endfunction

    // Fold the 64-byte block into the chaining words
    function void compress_block();
      logic [31:0] w [64];
      logic [31:0] v [8];
      logic [31:0] t1;
      logic [31:0] t2;
      for (int t = 0; t < 16; t++)
        w[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
      for (int t = 16; t < 64; t++)
        w[t] = (rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7]
             + (rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
      v = chain;
      for (int t = 0; t < 64; t++) begin
        t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_CONST[t] + w[t];
        t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6];
        v[6] = v[5];
        v[5] = v[4];
        v[4] = v[3] + t1;
        v[3] = v[2];
        v[2] = v[1];
        v[1] = v[0];
        v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain[i] += v[i];
    endfunction

    // Apply one accepted request and queue the words it produces
    function void take_request(logic req, logic [7:0] data);
      logic [63:0]      next_len;
      int unsigned      p;
      sha_pkg::result_t word;
      if (req == sha_pkg::REQ_APPEND) begin
        // drop bytes once the length has wrapped
        if (len_wrapped) return;
        msg_block[fill] = data;
        fill = (fill + 1) % 64;
        next_len = bit_len + 64'd8;
        if (next_len < bit_len) begin
          bit_len     = next_len;
          len_wrapped = 1'b1;
          return;
        end
        bit_len = next_len;
        if (fill == 0) compress_block();
        return;
      end
      // finish after a wrapped length: one zero word flagged as overflow
      if (len_wrapped) begin
        word = '{digest_word: '0, word_index: '0, last_word: 1'b1, overflow: 1'b1};
        owed_words.push_back(word);
        restart();
        return;
      end
      // pad: marker, zeros, big-endian length; spill into a second block if needed
      p = fill;
      msg_block[p] = 8'h80;
      p++;
      if (p > 56) begin
        while (p < 64) begin
          msg_block[p] = '0;
          p++;
        end
        compress_block();
        p = 0;
      end
      while (p < 56) begin
        msg_block[p] = '0;
        p++;
      end
      for (int i = 0; i < 8; i++) msg_block[56+i] = bit_len[63-8*i -: 8];
      compress_block();
      for (int i = 0; i < 8; i++) begin
        word = '{digest_word: chain[i], word_index: 3'(i), last_word: (i == 7),
                 overflow: 1'b0};
        owed_words.push_back(word);
      end
      restart();
    endfunction

    // Compare one transferred result with the oldest owed word
    function void compare_word(logic [31:0] digest, logic [2:0] idx, logic last,
                               logic ovf);
      sha_pkg::result_t owed;
      words_seen++;
      if (owed_words.size() == 0) begin
        $error("unexpected result: digest_word %h word_index %0d", digest, idx);
        mismatch_count++;
        return;
      end
      owed = owed_words.pop_front();
      if (digest !== owed.digest_word) begin
        $error("digest_word: expected %h, got %h", owed.digest_word, digest);
        mismatch_count++;
      end
      if (idx !== owed.word_index) begin
        $error("word_index: expected %0d, got %0d", owed.word_index, idx);
        mismatch_count++;
      end
      if (last !== owed.last_word) begin
        $error("last_word: expected %b, got %b", owed.last_word, last);
        mismatch_count++;
      end
      if (ovf !== owed.overflow) begin
        $error("overflow: expected %b, got %b", owed.overflow, ovf);
        mismatch_count++;
      end
    endfunction

    // Flag every word that never showed up
    function void report_missing();
      foreach (owed_words[i]) begin
        $error("missing result: digest_word %h word_index %0d",
               owed_words[i].digest_word, owed_words[i].word_index);
        mismatch_count++;
      end
    endfunction
  endclass

endpackage

@@ sim/sha256_byte_stream_hasher_core_test.sv @@
`timescale 1ns / 1ps

module sha256_byte_stream_hasher_core_test;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic        req_type = sha_pkg::REQ_APPEND;
  logic [7:0]  data_byte = 8'h00;
  logic        empty;
  logic        pop = 1'b0;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  logic        overflow;

  bit          steady = 1'b0;
  int unsigned items_sent = 0;
  int unsigned msgs_sent = 0;
  int unsigned bytes_sent = 0;

  sha256_digest_words_pkg::sha256_digest_words digests = new();

  sha256_byte_stream_hasher_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .req_type_i   (req_type),
    .data_byte_i  (data_byte),
    .empty        (empty),
    .pop          (pop),
    .digest_word_o(digest_word),
    .word_index_o (word_index),
    .last_word_o  (last_word),
    .overflow_o   (overflow)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Hold one request until it transfers, with random gaps ahead of it
  task automatic send_request(input logic req, input logic [7:0] data);
    @(negedge clk_i);
    while (!steady && $urandom_range(99) < 26) begin
      push      = 1'b0;
      req_type  = 1'($urandom);
      data_byte = 8'($urandom);
      @(negedge clk_i);
    end
    push      = 1'b1;
    req_type  = req;
    data_byte = data;
    do @(posedge clk_i); while (full);
    digests.take_request(req, data);
    items_sent++;
    if (req == sha_pkg::REQ_APPEND) bytes_sent++;
    else msgs_sent++;
  endtask

  // Random bytes of the given length, then a finish
  task automatic send_message(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) send_request(sha_pkg::REQ_APPEND, 8'($urandom));
    send_request(sha_pkg::REQ_FINISH, 8'($urandom));
  endtask

  // Result side: pop at random, check every transfer
  initial begin
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      pop = steady || ($urandom_range(99) >= 26);
      @(posedge clk_i);
      if (pop && !empty) digests.compare_word(digest_word, word_index, last_word, overflow);
    end
  end

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // empty messages back to back, finish carrying both byte extremes
    send_request(sha_pkg::REQ_FINISH, 8'hff);
    send_request(sha_pkg::REQ_FINISH, 8'h00);
    // "abc"
    send_request(sha_pkg::REQ_APPEND, 8'h61);
    send_request(sha_pkg::REQ_APPEND, 8'h62);
    send_request(sha_pkg::REQ_APPEND, 8'h63);
    send_request(sha_pkg::REQ_FINISH, 8'h55);
    // byte extremes and a byte equal to the pad marker
    send_request(sha_pkg::REQ_APPEND, 8'h00);
    send_request(sha_pkg::REQ_APPEND, 8'hff);
    send_request(sha_pkg::REQ_APPEND, 8'h80);
    send_request(sha_pkg::REQ_FINISH, 8'haa);

    // padding boundaries: length fits, length spills, full block plus pad block
    send_message(55);
    send_message(56);
    send_message(63);
    steady = 1'b1;
    send_message(64);
    steady = 1'b0;

    // random lengths, mostly short, some across block edges
    while (items_sent < 370) begin
      case ($urandom_range(9))
        7, 8:    send_message($urandom_range(50, 70));
        9:       send_message($urandom_range(110, 130));
        default: send_message($urandom_range(0, 16));
      endcase
    end

    @(negedge clk_i);
    push = 1'b0;

    // drain, then watch for stray results
    while (digests.owed_words.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    digests.report_missing();

    $display("Hashed %0d messages from %0d bytes; checked %0d digest words.",
             msgs_sent, bytes_sent, digests.words_seen);
    if (digests.mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Timeout waiting for the hasher");
    $display("Test completed with failures");
    $finish;
  end

endmodule
